[design/life_pkg.sv]
`default_nettype none
package life_pkg;
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;
    localparam logic [2:0] ACT_CLEAR   = 3'd0;
    localparam logic [2:0] ACT_TOGGLE  = 3'd1;
    localparam logic [2:0] ACT_ADVANCE = 3'd2;
    localparam logic [2:0] ACT_READ    = 3'd3;
    localparam logic [2:0] ACT_UNMARK  = 3'd4;
    localparam logic REG_ROWS = 1'b0;
    localparam logic REG_COLS = 1'b1;
endpackage
`default_nettype wire

[design/life_automaton_torus_grid_core.sv]
`default_nettype none
// read and unknown actions go straight to the result states; toggle writes the cell first
// clear grid and clear marks sweep every stored entry, not only the cells in use
// advance: a mark clear sweep over every stored entry, then for each cell in use the nine
// neighbor reads, then a copy back pass over the cells in use; all run on single-port memories
// throughput: one word at a time, busy drops with the strobe; the receiver cannot stall
// reset: cells and marks are cleared by a sweep over every stored entry, busy high
module life_automaton_torus_grid_core #(
    parameter int MAX_ROWS = life_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = life_pkg::MAX_COLS_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    input  wire        start,
    output logic       busy,
    input  wire [2:0]  action,
    input  wire [11:0] cell_index,
    output logic       done,
    output logic       alive,
    output logic       changed,
    output logic       bad_index,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire        cfg_index,
    input  wire [6:0]  cfg_data
);
    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW = $clog2(DEPTH);
    localparam int RW = $clog2(MAX_ROWS + 1);
    localparam int CW = $clog2(MAX_COLS + 1);
    localparam int NW = RW + CW;

    localparam logic [3:0] S_INIT = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_RES  = 4'd3;
    localparam logic [3:0] S_FILL = 4'd4;
    localparam logic [3:0] S_NB   = 4'd5;
    localparam logic [3:0] S_NBW  = 4'd6;
    localparam logic [3:0] S_CPR  = 4'd7;
    localparam logic [3:0] S_CPW  = 4'd8;
    localparam logic [3:0] S_TGW  = 4'd9;
    localparam logic [3:0] S_OUT  = 4'd10;

    // cell, mark and scratch memories, registered read
    logic cell_mem [DEPTH];
    logic mark_mem [DEPTH];
    logic next_mem [DEPTH];
    logic cell_q, mark_q, next_q;
    logic [AW-1:0] addr;
    logic cell_we, mark_we, next_we, cell_d, mark_d, next_d;

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[addr] <= cell_d;
        cell_q <= cell_mem[addr];
        if (mark_we)
            mark_mem[addr] <= mark_d;
        mark_q <= mark_mem[addr];
        if (next_we)
            next_mem[addr] <= next_d;
        next_q <= next_mem[addr];
    end

    logic [6:0] rows_cfg_reg, cols_cfg_reg;
    logic [3:0] state_reg, state_next;
    logic [2:0] act_reg;
    logic [AW-1:0] idx_reg;
    logic [NW-1:0] k_reg, k_next;           // sweep position
    logic [RW-1:0] r_reg, r_next;
    logic [CW-1:0] c_reg, c_next;
    logic [3:0] nbi_reg, nbi_next;          // neighbor position 0..8, 9..11 = drain
    logic [3:0] cnt_reg, cnt_next;
    logic self_reg, self_next;
    logic bad_reg;
    logic done_reg, alive_reg, changed_reg, bad_out_reg;

    // effective sizes: 0 counts as 1, saturate at max
    logic [RW-1:0] nr;
    logic [CW-1:0] nc;
    always_comb
    begin
        if (rows_cfg_reg == 7'd0)
            nr = RW'(1);
        else if (32'(rows_cfg_reg) > MAX_ROWS)
            nr = RW'(MAX_ROWS);
        else
            nr = RW'(rows_cfg_reg);
        if (cols_cfg_reg == 7'd0)
            nc = CW'(1);
        else if (32'(cols_cfg_reg) > MAX_COLS)
            nc = CW'(MAX_COLS);
        else
            nc = CW'(cols_cfg_reg);
    end
    // cells in use, follows a size write at once
    logic [NW-1:0] grid_cells;
    assign grid_cells = NW'(nr) * NW'(nc);

    // neighbor address for position nbi around (r, c)
    logic [RW-1:0] nb_r;
    logic [CW-1:0] nb_c;
    logic [NW-1:0] nb_addr;
    always_comb
    begin
        case (nbi_reg) inside
            4'd0, 4'd1, 4'd2: nb_r = (r_reg == '0) ? nr - RW'(1) : r_reg - RW'(1);
            4'd6, 4'd7, 4'd8: nb_r = (r_reg + RW'(1) >= nr) ? '0 : r_reg + RW'(1);
            default:          nb_r = r_reg;
        endcase
        case (nbi_reg) inside
            4'd0, 4'd3, 4'd6: nb_c = (c_reg == '0) ? nc - CW'(1) : c_reg - CW'(1);
            4'd2, 4'd5, 4'd8: nb_c = (c_reg + CW'(1) >= nc) ? '0 : c_reg + CW'(1);
            default:          nb_c = c_reg;
        endcase
    end
    logic [NW-1:0] row_base_reg;
    always_ff @(posedge clk)
        row_base_reg <= NW'(nb_r) * NW'(nc);
    // row base is registered; stage one: pipelined neighbor address
    logic [CW-1:0] nb_c_reg;
    logic [3:0] nbi_d_reg;
    always_ff @(posedge clk)
    begin
        nb_c_reg <= nb_c;
        nbi_d_reg <= nbi_reg;
    end
    assign nb_addr = row_base_reg + NW'(nb_c_reg);

    logic new_cell;
    always_comb
    begin
        if (self_reg)
            new_cell = (cnt_reg == 4'd2) || (cnt_reg == 4'd3);
        else
            new_cell = (cnt_reg == 4'd3);
    end

    // state machine; the neighbor sweep uses nbi 0..8 to issue, then the address register and the read
    logic [3:0] nbd2_reg;
    always_ff @(posedge clk)
        nbd2_reg <= nbi_d_reg;

    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        r_next = r_reg;
        c_next = c_reg;
        nbi_next = nbi_reg;
        cnt_next = cnt_reg;
        self_next = self_reg;
        addr = idx_reg;
        cell_we = 1'b0; mark_we = 1'b0; next_we = 1'b0;
        cell_d = 1'b0; mark_d = 1'b0; next_d = new_cell;
        unique case (state_reg)
            S_INIT:
            begin
                addr = AW'(k_reg);
                cell_we = 1'b1; mark_we = 1'b1;
                k_next = k_reg + NW'(1);
                if (32'(k_reg) == DEPTH - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                k_next = '0; r_next = '0; c_next = '0; nbi_next = '0; cnt_next = '0;
                if (start)
                    state_next = S_RD;
            end
            S_RD:
            begin
                // marks outside the grid in use must also clear on advance: a clear sweep first
                if (bad_reg)
                    state_next = S_RES;
                else
                    case (act_reg) inside
                        life_pkg::ACT_CLEAR, life_pkg::ACT_UNMARK, life_pkg::ACT_ADVANCE:
                            state_next = S_FILL;
                        life_pkg::ACT_TOGGLE: state_next = S_TGW;
                        default: state_next = S_RES;
                    endcase
            end
            S_TGW:
            begin
                cell_we = 1'b1; cell_d = ~cell_q;
                mark_we = 1'b1; mark_d = 1'b1;
                state_next = S_RES;
            end
            S_FILL:
            begin
                addr = AW'(k_reg);
                mark_we = 1'b1;
                mark_d = (act_reg == life_pkg::ACT_CLEAR);
                cell_we = (act_reg == life_pkg::ACT_CLEAR);
                k_next = k_reg + NW'(1);
                if (32'(k_reg) == DEPTH - 1)
                begin
                    // advance: the generation sweep follows the mark clear
                    if (act_reg == life_pkg::ACT_ADVANCE)
                    begin
                        state_next = S_NB;
                        k_next = '0;
                    end
                    else
                        state_next = S_RES;
                end
            end
            S_NB:
            begin
                // issue neighbor nbi_d (address ready), accumulate data from nbd2
                addr = AW'(nb_addr);
                if (nbi_reg != 4'd9 && nbi_reg != 4'd10 && nbi_reg != 4'd11)
                    nbi_next = nbi_reg + 4'd1;
                if (nbd2_reg <= 4'd8 && nbi_reg >= 4'd2)
                begin
                    if (nbd2_reg == 4'd4)
                        self_next = cell_q;
                    else
                        cnt_next = cnt_reg + {3'd0, cell_q};
                end
                if (nbi_reg == 4'd11)
                    state_next = S_NBW;
                else if (nbi_reg >= 4'd9)
                    nbi_next = nbi_reg + 4'd1;
            end
            S_NBW:
            begin
                addr = AW'(k_reg);
                next_we = 1'b1;
                mark_we = 1'b1;
                mark_d = (new_cell != self_reg);
                cnt_next = '0;
                nbi_next = '0;
                k_next = k_reg + NW'(1);
                if (c_reg + CW'(1) >= nc)
                begin
                    c_next = '0;
                    r_next = r_reg + RW'(1);
                end
                else
                    c_next = c_reg + CW'(1);
                if (k_reg + NW'(1) >= grid_cells)
                begin
                    state_next = S_CPR;
                    k_next = '0;
                end
                else
                    state_next = S_NB;
            end
            S_CPR:
            begin
                addr = AW'(k_reg);
                state_next = S_CPW;
            end
            S_CPW:
            begin
                addr = AW'(k_reg);
                cell_we = 1'b1; cell_d = next_q;
                k_next = k_reg + NW'(1);
                if (k_reg + NW'(1) >= grid_cells)
                    state_next = S_RES;
                else
                    state_next = S_CPR;
            end
            S_RES:
            begin
                // wait for the registered read of the addressed cell
                state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            k_reg <= '0;
            r_reg <= '0;
            c_reg <= '0;
            nbi_reg <= '0;
            cnt_reg <= '0;
            self_reg <= 1'b0;
            rows_cfg_reg <= 7'd64;
            cols_cfg_reg <= 7'd64;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == S_OUT);
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == life_pkg::REG_ROWS)
                    rows_cfg_reg <= cfg_data;
                else
                    cols_cfg_reg <= cfg_data;
            end
            state_reg <= state_next;
            k_reg <= k_next;
            r_reg <= r_next;
            c_reg <= c_next;
            nbi_reg <= nbi_next;
            cnt_reg <= cnt_next;
            self_reg <= self_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            act_reg <= action;
            idx_reg <= AW'(cell_index);
            bad_reg <= ({20'd0, cell_index} >= 32'(grid_cells)) || (32'(cell_index) >= DEPTH);
        end
        if (state_reg == S_OUT)
        begin
            bad_out_reg <= bad_reg;
            alive_reg <= bad_reg ? 1'b0 : cell_q;
            changed_reg <= bad_reg ? 1'b0 : mark_q;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) || (state_reg == S_INIT);
    assign done = done_reg;
    assign alive = alive_reg;
    assign changed = changed_reg;
    assign bad_index = bad_out_reg;
endmodule
`default_nettype wire

[design/life_checker.sv]
`default_nettype none
module life_checker (
    input wire clk,
    input wire rst_n,
    input wire start,
    input wire busy,
    input wire done,
    input wire alive,
    input wire changed,
    input wire bad_index
);
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy) else $error("start not taken");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy) else $error("strobe while busy");
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && bad_index |-> !alive && !changed) else $error("bad index data");
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("double strobe");
endmodule
bind life_automaton_torus_grid_core life_checker u_chk (.*);
`default_nettype wire
